// ----- rtl/orb_pkg.sv -----
// Shared types, constants and the arctangent table for the circle orbit step.
// Used by orb_vector, orb_rotate and circle_orbit_step_top; depends on nothing.
package orb_pkg;

	localparam int TABLE_LEN = 24;
	localparam int ACC_W = 32;
	localparam int VEC_W = 35;
	localparam int ROT_W = 34;
	localparam int ANG_W = 16;
	localparam int RAD_W = 15;
	localparam int RK_W = 31;
	localparam int GUARD_BITS = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int COORD_BITS_DEF = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	localparam logic [ACC_W-1:0] GAIN_INV = 32'd2608131496;
	localparam logic [ACC_W-1:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [ACC_W-1:0] THREE_QUARTER_TURN = 32'hC000_0000;
	localparam logic [RAD_W-1:0] RADIUS_RESET = 15'd256;

	localparam logic [ACC_W-1:0] ATAN_TAB [TABLE_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORBIT_RADIUS = 2'd0,
		REG_ANGLE_STEP   = 2'd1
	} cfg_reg_t;

endpackage

// ----- rtl/orb_vector.sv -----
// Pipelined vectoring CORDIC: finds the polar angle of a point as a 32-bit binary angle.
// One micro-rotation per register stage; depends on orb_pkg.
module orb_vector
	import orb_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
	parameter int TAG_W = 2 * COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic signed [COORD_BITS-1:0] in_x,
	input  logic signed [COORD_BITS-1:0] in_y,
	input  logic [TAG_W-1:0]             in_tag,
	output logic                         out_valid,
	output logic [ACC_W-1:0]             out_acc,
	output logic                         out_zero,
	output logic [TAG_W-1:0]             out_tag
);

	localparam int N = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
	localparam int SHIFT = ACC_W - COORD_BITS;

	logic signed [VEC_W-1:0] x_s [N+1];
	logic signed [VEC_W-1:0] y_s [N+1];
	logic [ACC_W-1:0]        acc_s [N+1];
	logic [TAG_W-1:0]        tag_s [N+1];
	logic [N:0]              zero_s;
	logic [N:0]              valid_s;

	logic signed [VEC_W-1:0] xe, ye, px, py;
	logic [ACC_W-1:0]        pa;

	// Points in the left half plane are turned by a quarter turn first.
	always_comb begin
		xe = VEC_W'(in_x) <<< SHIFT;
		ye = VEC_W'(in_y) <<< SHIFT;
		if (xe[VEC_W-1]) begin
			if (!ye[VEC_W-1]) begin
				px = ye;
				py = -xe;
				pa = QUARTER_TURN;
			end else begin
				px = -ye;
				py = xe;
				pa = THREE_QUARTER_TURN;
			end
		end else begin
			px = xe;
			py = ye;
			pa = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[N-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= px;
			y_s[0] <= py;
			acc_s[0] <= pa;
			zero_s <= {zero_s[N-1:0], (in_x == '0) && (in_y == '0)};
			tag_s[0] <= in_tag;
			for (int k = 1; k <= N; k++) begin
				tag_s[k] <= tag_s[k-1];
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		logic signed [VEC_W-1:0] dx, dy;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i][VEC_W-1]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					acc_s[i+1] <= acc_s[i] - ATAN_TAB[i];
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					acc_s[i+1] <= acc_s[i] + ATAN_TAB[i];
				end
			end
		end
	end

	assign out_valid = valid_s[N];
	assign out_acc = acc_s[N];
	assign out_zero = zero_s[N];
	assign out_tag = tag_s[N];

endmodule

// ----- rtl/orb_rotate.sv -----
// Pipelined rotating CORDIC: places a point of a given scaled radius at a 16-bit angle.
// One micro-rotation per register stage; depends on orb_pkg.
module orb_rotate
	import orb_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
	parameter int TAG_W = 2 * COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [ANG_W-1:0]        in_ang,
	input  logic [RK_W-1:0]         in_rk,
	input  logic [TAG_W-1:0]        in_tag,
	output logic                    out_valid,
	output logic signed [ROT_W-1:0] out_x,
	output logic signed [ROT_W-1:0] out_y,
	output logic [TAG_W-1:0]        out_tag
);

	localparam int N = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
	localparam logic signed [ROT_W-1:0] QTR = ROT_W'(QUARTER_TURN);

	logic signed [ROT_W-1:0] x_s [N+1];
	logic signed [ROT_W-1:0] y_s [N+1];
	logic signed [ROT_W-1:0] z_s [N+1];
	logic [TAG_W-1:0]        tag_s [N+1];
	logic [N:0]              valid_s;

	logic signed [ROT_W-1:0] za, rke, px, py, pz;

	always_comb begin
		za = ROT_W'(signed'({in_ang, {(ACC_W-ANG_W){1'b0}}}));
		rke = signed'(ROT_W'(in_rk));
		if (za > QTR) begin
			px = '0;
			py = rke;
			pz = za - QTR;
		end else if (za < -QTR) begin
			px = '0;
			py = -rke;
			pz = za + QTR;
		end else begin
			px = rke;
			py = '0;
			pz = za;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[N-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= px;
			y_s[0] <= py;
			z_s[0] <= pz;
			tag_s[0] <= in_tag;
			for (int k = 1; k <= N; k++) begin
				tag_s[k] <= tag_s[k-1];
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		logic signed [ROT_W-1:0] dx, dy;
		logic [ROT_W-1:0]        da;

		assign dx = x_s[i] >>> i;
		assign dy = y_s[i] >>> i;
		assign da = ROT_W'(ATAN_TAB[i]);

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][ROT_W-1]) begin
					x_s[i+1] <= x_s[i] - dy;
					y_s[i+1] <= y_s[i] + dx;
					z_s[i+1] <= z_s[i] - signed'(da);
				end else begin
					x_s[i+1] <= x_s[i] + dy;
					y_s[i+1] <= y_s[i] - dx;
					z_s[i+1] <= z_s[i] + signed'(da);
				end
			end
		end
	end

	assign out_valid = valid_s[N];
	assign out_x = x_s[N];
	assign out_y = y_s[N];
	assign out_tag = tag_s[N];

endmodule

// ----- rtl/circle_orbit_step_top.sv -----
// Top level of the circle orbit step: register file, angle and output stages, two CORDICs.
// Depends on orb_pkg, orb_vector and orb_rotate.
//
// Channel   Direction  Handshake          Content
// cfg       in         cfg_valid/ready    cfg_index, cfg_data (radius or angle step)
// s_axis    in         s_tvalid/tready    pos_x, pos_y, noise_x, noise_y
// m_axis    out        m_tvalid/tready    next_x, next_y in tdata, clipped in tuser
//
// One word is taken every cycle while the output is not stalled; a word passes through the
// vectoring CORDIC, the angle stage, the rotating CORDIC and the output stage in that order.
// Reset clears the valid bits and loads the registers with radius 256 and step 0.
// A stall at the output freezes the whole pipeline, so nothing is dropped or repeated.
module circle_orbit_step_top
	import orb_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
	localparam int IN_W = ((4 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,  // pos_x, pos_y, noise_x, noise_y, zero padding
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,  // next_x, next_y, zero padding
	output logic [0:0]            m_tuser   // clipped
);

	localparam int TAG_W = 2 * COORD_BITS;
	localparam int CX_W = ROT_W - GUARD_BITS;
	localparam int SUM_W = ((COORD_BITS > CX_W) ? COORD_BITS : CX_W) + 1;
	localparam int PROD_W = RAD_W + ACC_W;
	localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(COORD_MAX);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(COORD_MIN);

	logic [RAD_W-1:0]  radius_q;
	logic [ANG_W-1:0]  step_q;
	logic [RK_W-1:0]   rk_q;
	logic [PROD_W-1:0] rk_prod;

	logic adv;

	logic signed [COORD_BITS-1:0] pos_x, pos_y, noise_x, noise_y;

	logic              vec_valid, vec_zero;
	logic [ACC_W-1:0]  vec_acc;
	logic [TAG_W-1:0]  vec_tag;
	logic [ANG_W-1:0]  ang_round;

	logic              ang_valid_s1;
	logic [ANG_W-1:0]  ang_s1;
	logic [TAG_W-1:0]  tag_s1;

	logic                    rot_valid;
	logic signed [ROT_W-1:0] rot_x, rot_y, rnd_x, rnd_y;
	logic [TAG_W-1:0]        rot_tag;
	logic signed [CX_W-1:0]  cx, cy;
	logic signed [COORD_BITS-1:0] rot_nx, rot_ny;
	logic signed [SUM_W-1:0] sum_x, sum_y;
	logic signed [COORD_BITS-1:0] sat_x, sat_y;
	logic                    clip_x, clip_y;

	logic                    valid_s2;
	logic signed [COORD_BITS-1:0] res_x_s2, res_y_s2;
	logic                    clip_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			step_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ORBIT_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
				REG_ANGLE_STEP:   step_q <= cfg_data[ANG_W-1:0];
				default: ;
			endcase
		end
	end

	// Start radius of the rotation, pre-scaled by the inverse CORDIC gain.
	assign rk_prod = PROD_W'(radius_q) * PROD_W'(GAIN_INV);

	always_ff @(posedge clk) begin
		rk_q <= RK_W'((rk_prod + PROD_W'(1 << (GUARD_BITS - 1))) >> GUARD_BITS);
	end

	assign adv = !valid_s2 || m_tready;
	assign s_tready = adv;

	assign pos_x = s_tdata[COORD_BITS-1:0];
	assign pos_y = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign noise_x = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
	assign noise_y = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

	orb_vector #(
		.COORD_BITS(COORD_BITS),
		.CORDIC_STAGES(CORDIC_STAGES),
		.TAG_W(TAG_W)
	) u_vector (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(s_tvalid),
		.in_x(pos_x),
		.in_y(pos_y),
		.in_tag({noise_y, noise_x}),
		.out_valid(vec_valid),
		.out_acc(vec_acc),
		.out_zero(vec_zero),
		.out_tag(vec_tag)
	);

	// The origin has angle zero; otherwise round the accumulated angle to 16 bits.
	assign ang_round = vec_zero ? '0
		: vec_acc[ACC_W-1 -: ANG_W] + ANG_W'(vec_acc[ACC_W-ANG_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_valid_s1 <= 1'b0;
		end else if (adv) begin
			ang_valid_s1 <= vec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s1 <= ang_round + step_q;
			tag_s1 <= vec_tag;
		end
	end

	orb_rotate #(
		.CORDIC_STAGES(CORDIC_STAGES),
		.TAG_W(TAG_W)
	) u_rotate (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(ang_valid_s1),
		.in_ang(ang_s1),
		.in_rk(rk_q),
		.in_tag(tag_s1),
		.out_valid(rot_valid),
		.out_x(rot_x),
		.out_y(rot_y),
		.out_tag(rot_tag)
	);

	assign rnd_x = rot_x + ROT_W'(1 << (GUARD_BITS - 1));
	assign rnd_y = rot_y + ROT_W'(1 << (GUARD_BITS - 1));
	assign cx = rnd_x[ROT_W-1:GUARD_BITS];
	assign cy = rnd_y[ROT_W-1:GUARD_BITS];
	assign rot_nx = rot_tag[COORD_BITS-1:0];
	assign rot_ny = rot_tag[2*COORD_BITS-1:COORD_BITS];
	assign sum_x = SUM_W'(cx) + SUM_W'(rot_nx);
	assign sum_y = SUM_W'(cy) + SUM_W'(rot_ny);

	always_comb begin
		clip_x = 1'b1;
		clip_y = 1'b1;
		if (sum_x > SAT_HI) begin
			sat_x = COORD_MAX;
		end else if (sum_x < SAT_LO) begin
			sat_x = COORD_MIN;
		end else begin
			sat_x = sum_x[COORD_BITS-1:0];
			clip_x = 1'b0;
		end
		if (sum_y > SAT_HI) begin
			sat_y = COORD_MAX;
		end else if (sum_y < SAT_LO) begin
			sat_y = COORD_MIN;
		end else begin
			sat_y = sum_y[COORD_BITS-1:0];
			clip_y = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= rot_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_x_s2 <= sat_x;
			res_y_s2 <= sat_y;
			clip_s2 <= clip_x || clip_y;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = OUT_W'({res_y_s2, res_x_s2});
	assign m_tuser = clip_s2;

	a_stall_holds_angle: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(ang_s1) && $stable(ang_valid_s1))
		else $error("angle stage changed while the pipeline was stalled");

	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && clip_s2 |-> res_x_s2 == COORD_MAX || res_x_s2 == COORD_MIN
			|| res_y_s2 == COORD_MAX || res_y_s2 == COORD_MIN)
		else $error("clipped flag set without a coordinate at its limit");

	a_zero_radius: assert property (@(posedge clk) disable iff (!arst_n)
		radius_q == '0 && $stable(radius_q) |-> rk_q == '0)
		else $error("scaled radius is not zero for a zero orbit radius");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for circle_orbit_step_top: a directed table, then random particle words.
// Expected positions come from a predictor of both CORDIC passes; depends on orb_pkg and the RTL.
module tb_top;
	import orb_pkg::*;

	localparam int COORD_W = COORD_BITS_DEF;
	localparam int ARC_STEPS = 16;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES = 13;
	localparam int WORDS_PER_PHASE = 100;
	localparam longint unsigned RK_GAIN = 64'd2608131496;
	localparam longint RIGHT_ANGLE = 64'sd1073741824;
	localparam logic signed [COORD_W-1:0] C_MAX = 16'sh7FFF;
	localparam logic signed [COORD_W-1:0] C_MIN = 16'sh8000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
	localparam logic [31:0] ARC_TABLE [ARC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
	};

	typedef struct packed {
		logic                      clip;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} orbit_point_t;

	typedef struct {
		bit                        reg_write;
		logic [CFG_IDX_W-1:0]      idx;
		logic [CFG_DATA_W-1:0]     data;
		logic signed [COORD_W-1:0] px, py, nx, ny;
		bit                        typed;
		orbit_point_t              fixed;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [63:0]           s_tdata;  // pos_x, pos_y, noise_x, noise_y
	logic                  m_tvalid;
	logic                  m_tready;
	logic [31:0]           m_tdata;  // next_x, next_y
	logic [0:0]            m_tuser;  // clipped

	logic [RAD_W-1:0]   radius_reg;
	logic [ANG_W-1:0]   step_reg;
	orbit_point_t       pending_positions[$];
	stim_row_t          directed_rows[$];
	bit                 calm;
	int                 words_sent;
	int                 results_checked = 0;
	int                 regs_written;
	int                 mismatches = 0;
	int                 idle_cycles = 0;

	circle_orbit_step_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Vectoring pass: polar angle of the particle, rounded to a 16-bit binary angle.
	function automatic logic [ANG_W-1:0] heading_of(input longint px, input longint py);
		longint x, y, t, dx, dy;
		logic [31:0] acc, rounded;
		int i;
		if (px == 0 && py == 0)
			return '0;
		x = px * 65536;
		y = py * 65536;
		acc = '0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; acc = 32'h4000_0000;
			end else begin
				t = x; x = -y; y = t; acc = 32'hC000_0000;
			end
		end
		for (i = 0; i < ARC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y < 0) begin
				x -= dx; y += dy; acc -= ARC_TABLE[i];
			end else begin
				x += dx; y -= dy; acc += ARC_TABLE[i];
			end
		end
		rounded = acc + 32'h8000;
		return rounded[31:16];
	endfunction

	// Rotation pass: point on the circle of the current radius at the given angle.
	function automatic void orbit_point_at(input logic [ANG_W-1:0] heading,
			output longint cx, output longint cy);
		logic [31:0] a;
		longint z, x, y, dx, dy, rk;
		longint unsigned prod;
		int i;
		a = {heading, 16'h0000};
		z = longint'(signed'(a));
		prod = 64'(radius_reg) * RK_GAIN + 64'h8000;
		rk = longint'(prod >> 16);
		if (z > RIGHT_ANGLE) begin
			x = 0; y = rk; z -= RIGHT_ANGLE;
		end else if (z < -RIGHT_ANGLE) begin
			x = 0; y = -rk; z += RIGHT_ANGLE;
		end else begin
			x = rk; y = 0;
		end
		for (i = 0; i < ARC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ARC_TABLE[i]);
			end else begin
				x += dx; y -= dy; z += longint'(ARC_TABLE[i]);
			end
		end
		cx = (x + 64'sd32768) >>> 16;
		cy = (y + 64'sd32768) >>> 16;
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v, inout logic clip);
		if (v > 32767) begin
			clip = 1'b1;
			return C_MAX;
		end
		if (v < -32768) begin
			clip = 1'b1;
			return C_MIN;
		end
		return 16'(v);
	endfunction

	function automatic orbit_point_t predict_next_position(
			input logic signed [COORD_W-1:0] px, py, nx, ny);
		logic [ANG_W-1:0] heading;
		longint cx, cy;
		logic clip;
		orbit_point_t r;
		clip = 1'b0;
		heading = heading_of(px, py) + step_reg;
		orbit_point_at(heading, cx, cy);
		r.x = clamp_coord(longint'(nx) + cx, clip);
		r.y = clamp_coord(longint'(ny) + cy, clip);
		r.clip = clip;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		stim_row_t r;
		r = '{default: '0};
		r.reg_write = 1'b1;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic stim_row_t particle_row(input logic signed [COORD_W-1:0] px, py, nx, ny);
		stim_row_t r;
		r = '{default: '0};
		r.px = px;
		r.py = py;
		r.nx = nx;
		r.ny = ny;
		return r;
	endfunction

	function automatic stim_row_t pinned_row(input logic signed [COORD_W-1:0] px, py, nx, ny,
			input logic signed [COORD_W-1:0] ex, ey, input bit ec);
		stim_row_t r;
		r = particle_row(px, py, nx, ny);
		r.typed = 1'b1;
		r.fixed.x = ex;
		r.fixed.y = ey;
		r.fixed.clip = ec;
		return r;
	endfunction

	task automatic send_particle(input logic signed [COORD_W-1:0] px, py, nx, ny,
			input bit typed, input orbit_point_t fixed);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata = {ny, nx, py, px};
		s_tvalid = 1'b1;
		do @(posedge clk); while (s_tready !== 1'b1);
		pending_positions.push_back(typed ? fixed : predict_next_position(px, py, nx, ny));
		words_sent++;
		@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == REG_ORBIT_RADIUS)
			radius_reg = data[RAD_W-1:0];
		else if (idx == REG_ANGLE_STEP)
			step_reg = data;
		regs_written++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (pending_positions.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin : result_sink
		int hold;
		m_tready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				m_tready = 1'b0;
				hold--;
			end else begin
				m_tready = 1'b1;
				hold = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : check_results
		orbit_point_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.x = m_tdata[15:0];
			got.y = m_tdata[31:16];
			got.clip = m_tuser[0];
			if (pending_positions.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected word x=%0d y=%0d clipped=%0b", got.x, got.y, got.clip);
			end else begin
				want = pending_positions.pop_front();
				results_checked++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"Mismatch on word %0d: expected x=%0d y=%0d clipped=%0b,",
							" got x=%0d y=%0d clipped=%0b"},
							results_checked, want.x, want.y, want.clip,
							got.x, got.y, got.clip);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("circle_orbit_step_top test failed");
			$finish;
		end
	end

	initial begin : stimulus
		stim_row_t row;
		logic [CFG_DATA_W-1:0] rd, st;
		logic signed [COORD_W-1:0] px, py, nx, ny;
		int phase, m;
		int lost;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		calm = 1'b0;
		words_sent = 0;
		regs_written = 0;
		radius_reg = RADIUS_RESET;
		step_reg = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Rows with a pinned result either saturate both coordinates or use a zero radius,
		// so that the result is the noise word itself.
		directed_rows = '{
			particle_row(0, 0, 0, 0),
			particle_row(256, 0, 0, 0),
			particle_row(0, 256, 0, 0),
			particle_row(-256, 0, 0, 0),
			particle_row(0, -256, 0, 0),
			particle_row(C_MAX, C_MAX, 0, 0),
			particle_row(C_MIN, C_MIN, 0, 0),
			particle_row(C_MIN, C_MAX, 0, 0),
			particle_row(C_MAX, C_MIN, 0, 0),
			particle_row(1, 0, C_MAX, 0),
			pinned_row(256, 256, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1),
			pinned_row(-256, -256, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1),
			reg_row(REG_ORBIT_RADIUS, 16'h8000),
			reg_row(REG_SPARE_HI, 16'h7FFF),
			reg_row(REG_ANGLE_STEP, 16'h8000),
			pinned_row(123, -45, C_MAX, C_MIN, C_MAX, C_MIN, 1'b0),
			pinned_row(0, 0, C_MIN, C_MAX, C_MIN, C_MAX, 1'b0),
			pinned_row(-1, -1, 16'sh5555, 16'sh2AAA, 16'sh5555, 16'sh2AAA, 1'b0),
			reg_row(REG_ORBIT_RADIUS, 16'h7FFF),
			reg_row(REG_ANGLE_STEP, 16'h7FFF),
			particle_row(256, 0, 0, 0),
			particle_row(0, 0, C_MAX, C_MAX),
			particle_row(C_MIN, 0, C_MIN, C_MIN),
			particle_row(1, -1, 16'sh0100, 16'shFF00),
			reg_row(REG_SPARE_LO, 16'hFFFF),
			reg_row(REG_ORBIT_RADIUS, 16'h0001),
			reg_row(REG_ANGLE_STEP, 16'hFFFF),
			particle_row(0, 0, 0, 0),
			particle_row(-1, 0, 0, 0)
		};
		foreach (directed_rows[m]) begin
			row = directed_rows[m];
			if (row.reg_write) begin
				wait_drained();
				write_register(row.idx, row.data);
			end else begin
				send_particle(row.px, row.py, row.nx, row.ny, row.typed, row.fixed);
			end
		end

		for (phase = 0; phase < PHASES; phase++) begin
			wait_drained();
			case (phase)
				0: begin rd = 16'h7FFF; st = 16'h0000; end
				1: begin rd = 16'h0100; st = 16'h8000; end
				2: begin rd = 16'h0000; st = 16'h7FFF; end
				default: begin
					case ($urandom_range(0, 5))
						0: rd = 16'h0000;
						1: rd = 16'h7FFF;
						2: rd = 16'($urandom_range(1, 16));
						3: rd = 16'($urandom_range(128, 1024));
						default: rd = 16'($urandom_range(0, 32767));
					endcase
					if ($urandom_range(0, 4) == 0)
						rd[15] = 1'b1;
					case ($urandom_range(0, 7))
						0: st = 16'h8000;
						1: st = 16'h7FFF;
						2: st = 16'hFFFF;
						3: st = 16'h0000;
						default: st = 16'($urandom);
					endcase
				end
			endcase
			if ($urandom_range(0, 3) == 0)
				write_register($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
			if ($urandom_range(0, 1)) begin
				write_register(REG_ANGLE_STEP, st);
				write_register(REG_ORBIT_RADIUS, rd);
			end else begin
				write_register(REG_ORBIT_RADIUS, rd);
				write_register(REG_ANGLE_STEP, st);
			end
			calm = (phase % 4 == 3);
			repeat (WORDS_PER_PHASE) begin
				case ($urandom_range(0, 9))
					0: begin px = 0; py = 0; end
					1: begin
						if ($urandom_range(0, 1)) begin
							px = 0; py = 16'($urandom);
						end else begin
							px = 16'($urandom); py = 0;
						end
					end
					2: begin
						m = $urandom_range(1, 32767);
						px = $urandom_range(0, 1) ? 16'(m) : 16'(-m);
						py = $urandom_range(0, 1) ? 16'(m) : 16'(-m);
					end
					3, 4, 5: begin px = 16'($urandom); py = 16'($urandom); end
					default: begin
						px = 16'($urandom_range(0, 2047) - 1024);
						py = 16'($urandom_range(0, 2047) - 1024);
					end
				endcase
				case ($urandom_range(0, 9))
					6, 7: begin nx = 16'($urandom); ny = 16'($urandom); end
					8: begin
						nx = $urandom_range(0, 1) ? C_MAX : C_MIN;
						ny = $urandom_range(0, 1) ? C_MAX : C_MIN;
					end
					9: begin nx = 0; ny = 0; end
					default: begin
						nx = 16'($urandom_range(0, 127) - 64);
						ny = 16'($urandom_range(0, 127) - 64);
					end
				endcase
				send_particle(px, py, nx, ny, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (60) @(posedge clk);
		lost = pending_positions.size();
		if (lost != 0)
			$display("%0d expected words never arrived", lost);
		$display("Run covered %0d particle words and %0d register writes; %0d results compared.",
			words_sent, regs_written, results_checked);
		$display("Mismatches found: %0d", mismatches);
		if (mismatches == 0 && lost == 0)
			$display("circle_orbit_step_top test passed");
		else
			$display("circle_orbit_step_top test failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/orb_pkg.sv
rtl/orb_vector.sv
rtl/orb_rotate.sv
rtl/circle_orbit_step_top.sv
tb/tb_top.sv
